// ----- rtl/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants for the MIME boundary scanner: word layouts,
// opcodes, register indexes and control characters.
// ----------------------------------------------------------------------------
package mbs_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BODY  = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  localparam logic REG_BOUNDARY_LENGTH = 1'b0;
  localparam logic REG_RECHECK         = 1'b1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [6:0]  load_index;
    logic [31:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic        matched;
    logic [31:0] part_end;
    logic [31:0] part_data_end;
  } out_word_t;

  typedef struct packed {
    logic [7:0] boundary_length;
    logic       recheck_on_mismatch;
  } cfg_t;

endpackage

// ----- rtl/mbs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mbs_cfg_regs
// APB-style register file holding boundary length and mismatch mode.
// ----------------------------------------------------------------------------
module mbs_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mbs_pkg::cfg_t cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boundary_length     <= 8'd0;
      cfg.recheck_on_mismatch <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        mbs_pkg::REG_BOUNDARY_LENGTH: cfg.boundary_length     <= pwdata[7:0];
        mbs_pkg::REG_RECHECK:         cfg.recheck_on_mismatch <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mbs_pkg::REG_BOUNDARY_LENGTH: prdata = {24'd0, cfg.boundary_length};
      mbs_pkg::REG_RECHECK:         prdata = {31'd0, cfg.recheck_on_mismatch};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/mbs_boundary_mem.sv -----
// ----------------------------------------------------------------------------
// mbs_boundary_mem
// Boundary byte store: one write port, one registered read port with
// write-to-read forwarding, plus a register copy of the first byte.
// ----------------------------------------------------------------------------
module mbs_boundary_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic [7:0]    first_byte
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward a same-cycle write so the read word is never stale.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      first_byte <= wr_data;
    end
  end

endmodule

// ----- rtl/mbs_out_buf.sv -----
// ----------------------------------------------------------------------------
// mbs_out_buf
// Two-entry output buffer (output register plus skid) for result words.
// ----------------------------------------------------------------------------
module mbs_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mbs_pkg::out_word_t push_data,
  output logic               can_accept,
  output logic               out_valid,
  input  logic               out_ready,
  output mbs_pkg::out_word_t out_data
);

  logic               skid_valid;
  mbs_pkg::out_word_t skid_data;
  logic               pop;

  assign can_accept = ~skid_valid;
  assign pop        = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- rtl/mime_boundary_scanner_unit.sv -----
// Output: a result word is registered into the output buffer when the body
//   byte that causes it is accepted.
// Throughput: one input word per cycle unless the skid entry is full; the match
//   index loop runs through the store read port, addressed by the next index.
// Reset: rst clears offsets, match progress, config and the output buffer;
//   the boundary store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// mime_boundary_scanner_unit
// Scans multipart body bytes for a boundary string held in a byte store and
// reports body end and data end offsets on each complete match.
// ----------------------------------------------------------------------------
module mime_boundary_scanner_unit #(
  parameter int MAX_BOUNDARY = 128,
  parameter int OFFSET_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mbs_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Index width for the store, and a compare width that also holds the length.
  localparam int IW = $clog2(MAX_BOUNDARY);
  localparam int CW = IW + 1;

  mbs_pkg::cfg_t      cfg;
  mbs_pkg::out_word_t res;

  // Scanner state
  logic [IW-1:0]          match_index;
  logic [IW-1:0]          match_index_next;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] cr_position;
  logic [OFFSET_BITS-1:0] lf_position;

  // Store access
  logic [7:0]    cur_rd;
  logic [7:0]    first_byte;
  logic          mem_wr;

  logic          accept;
  logic          produce;
  logic [7:0]    b;
  logic [CW-1:0] len_eff;
  logic          no_bnd;
  logic [IW-1:0] mi_eff;
  logic [CW-1:0] mi_inc;
  logic [7:0]    cmp_byte;
  logic          hit;
  logic          hit_first;
  logic          done;
  logic [IW-1:0] mi_calc;

  logic [OFFSET_BITS-1:0] off_inc;
  logic [OFFSET_BITS-1:0] cr_new;
  logic [OFFSET_BITS-1:0] lf_new;
  logic [OFFSET_BITS-1:0] end_off;
  logic [OFFSET_BITS-1:0] dend_off;
  logic                   lf_adj;
  logic                   cr_adj;

  mbs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept = in_valid & in_ready;
  assign b      = in_data.data_byte;

  // Load words write the store; an index past the store is dropped.
  assign mem_wr = accept && (in_data.opcode == mbs_pkg::OP_LOAD) &&
                  (9'(in_data.load_index) < 9'(MAX_BOUNDARY));

  // The read port is always addressed with the index the next byte will use,
  // so the registered read word lines up with match_index.
  mbs_boundary_mem #(
    .DEPTH (MAX_BOUNDARY),
    .AW    (IW)
  ) u_mem (
    .clk        (clk),
    .wr_en      (mem_wr),
    .wr_addr    (IW'(in_data.load_index)),
    .wr_data    (b),
    .rd_addr    (match_index_next),
    .rd_data    (cur_rd),
    .first_byte (first_byte)
  );

  // Match step: compare against the entry at the effective index.
  always_comb begin
    len_eff = (9'(cfg.boundary_length) > 9'(MAX_BOUNDARY)) ?
              CW'(MAX_BOUNDARY) : CW'(cfg.boundary_length);
    no_bnd  = (len_eff == '0);

    // Drop a partial match left stale by a shorter length.
    mi_eff    = (CW'(match_index) >= len_eff) ? '0 : match_index;
    mi_inc    = CW'(mi_eff) + CW'(1);
    cmp_byte  = (mi_eff != '0) ? cur_rd : first_byte;
    hit       = (b == cmp_byte);
    hit_first = (b == first_byte);

    done    = 1'b0;
    mi_calc = '0;
    if (mi_eff != '0) begin
      if (hit) begin
        done    = (mi_inc == len_eff);
        mi_calc = done ? '0 : IW'(mi_inc);
      end else if (cfg.recheck_on_mismatch && hit_first) begin
        // Mismatching byte starts a fresh match; length is at least two here.
        mi_calc = IW'(1);
      end
    end else if (hit_first) begin
      done    = (len_eff == CW'(1));
      mi_calc = done ? '0 : IW'(1);
    end
  end

  // Offset bookkeeping and match report.
  always_comb begin
    off_inc  = byte_offset + OFFSET_BITS'(1);
    cr_new   = (b == mbs_pkg::CH_CR) ? byte_offset : cr_position;
    lf_new   = (b == mbs_pkg::CH_LF) ? byte_offset : lf_position;
    end_off  = off_inc - OFFSET_BITS'(len_eff);
    // LF right before the boundary, and CR right before that LF.
    lf_adj   = ((lf_new + OFFSET_BITS'(len_eff)) == byte_offset);
    cr_adj   = ((cr_new + OFFSET_BITS'(1)) == lf_new);
    dend_off = end_off;
    if (lf_adj) begin
      dend_off = end_off - (cr_adj ? OFFSET_BITS'(2) : OFFSET_BITS'(1));
    end

    if (no_bnd) begin
      res.matched       = 1'b0;
      res.part_end      = 32'(byte_offset);
      res.part_data_end = 32'(byte_offset);
    end else begin
      res.matched       = 1'b1;
      res.part_end      = 32'(end_off);
      res.part_data_end = 32'(dend_off);
    end

    produce = accept && (in_data.opcode == mbs_pkg::OP_BODY) && (no_bnd || done);
  end

  // Next match index also drives the store read address.
  always_comb begin
    match_index_next = match_index;
    if (accept) begin
      unique case (in_data.opcode)
        mbs_pkg::OP_BODY:  match_index_next = no_bnd ? match_index : mi_calc;
        mbs_pkg::OP_START: match_index_next = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_index <= '0;
      byte_offset <= '0;
      cr_position <= '0;
      lf_position <= '0;
    end else begin
      match_index <= match_index_next;
      if (accept) begin
        unique case (in_data.opcode)
          mbs_pkg::OP_BODY: begin
            // Advance the offset; track CR and LF only while a boundary is set.
            byte_offset <= off_inc;
            if (!no_bnd) begin
              cr_position <= cr_new;
              lf_position <= lf_new;
            end
          end
          mbs_pkg::OP_START: begin
            byte_offset <= OFFSET_BITS'(in_data.start_offset);
            cr_position <= '0;
            lf_position <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result words go to a two-entry buffer so input keeps flowing while a
  // result waits downstream.
  mbs_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (produce),
    .push_data  (res),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIME boundary scanner. Drives input words over
// valid/ready, programs the two registers over the APB port, predicts every
// result word in a scoreboard model and compares field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          BOUNDARY_DEPTH = 128;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          EXPECT_DEPTH   = 64;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [2:0]  ADDR_LENGTH    = {mbs_pkg::REG_BOUNDARY_LENGTH, 2'b00};
  localparam logic [2:0]  ADDR_RECHECK   = {mbs_pkg::REG_RECHECK, 2'b00};
  localparam logic [7:0]  CH_DASH        = 8'h2D;
  localparam logic [7:0]  CH_A           = 8'h61;
  localparam logic [7:0]  CH_B           = 8'h62;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  mbs_pkg::in_word_t   in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mbs_pkg::out_word_t  out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [2:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Handshake pressure, changed per phase.
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;

  int words_sent  = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Scanner model state, advanced as each input word is accepted.
  logic [7:0]  boundary_bytes [BOUNDARY_DEPTH];
  int          match_pos;
  logic [31:0] stream_pos;
  logic [31:0] cr_seen_pos;
  logic [31:0] lf_seen_pos;
  logic [7:0]  cfg_length;
  logic        cfg_recheck;

  // Expected reports in order: written by the model, read by the checker.
  mbs_pkg::out_word_t expect_ring [EXPECT_DEPTH];
  int                 expect_wr = 0;
  int                 expect_rd = 0;

  mime_boundary_scanner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up once the cycle budget is spent.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stall the result side at the phase's rate; zero means always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int pending_count();
    return expect_wr - expect_rd;
  endfunction

  // Append one expected report behind the ones still outstanding.
  task automatic queue_report(input mbs_pkg::out_word_t report);
    if (pending_count() >= EXPECT_DEPTH) begin
      $display("%0t: expected report store full: expected room actual %0d", $time,
               pending_count());
      error_count++;
    end else begin
      expect_ring[expect_wr % EXPECT_DEPTH] = report;
      expect_wr++;
    end
  endtask

  // Advance the model by one accepted word and queue any report it yields.
  task automatic scan_word(input mbs_pkg::in_word_t w);
    logic [7:0]         b;
    logic [31:0]        len_v;
    logic [31:0]        end_v;
    logic [31:0]        data_end_v;
    mbs_pkg::out_word_t report;
    bit                 done;
    b    = w.data_byte;
    done = 1'b0;
    case (w.opcode)
      mbs_pkg::OP_LOAD: begin
        boundary_bytes[w.load_index] = b;
      end
      mbs_pkg::OP_START: begin
        stream_pos  = w.start_offset;
        match_pos   = 0;
        cr_seen_pos = '0;
        lf_seen_pos = '0;
      end
      mbs_pkg::OP_BODY: begin
        len_v = (cfg_length > BOUNDARY_DEPTH) ? 32'(BOUNDARY_DEPTH) : 32'(cfg_length);
        if (len_v == 0) begin
          // No boundary: every byte reports its own offset.
          report.matched       = 1'b0;
          report.part_end      = stream_pos;
          report.part_data_end = stream_pos;
          queue_report(report);
          stream_pos = stream_pos + 32'd1;
        end else begin
          if (b == mbs_pkg::CH_CR) begin
            cr_seen_pos = stream_pos;
          end else if (b == mbs_pkg::CH_LF) begin
            lf_seen_pos = stream_pos;
          end
          stream_pos = stream_pos + 32'd1;
          // Drop a partial match left over from a longer boundary.
          if (match_pos >= len_v) match_pos = 0;
          if (cfg_recheck) begin
            if (match_pos != 0) begin
              if (b != boundary_bytes[match_pos]) begin
                match_pos = 0;
              end else begin
                match_pos++;
                if (match_pos == len_v) begin
                  match_pos = 0;
                  done      = 1'b1;
                end
              end
            end
            // Retest the breaking byte against the first boundary byte.
            if (!done && match_pos == 0 && b == boundary_bytes[0]) begin
              match_pos = 1;
              if (len_v == 1) begin
                match_pos = 0;
                done      = 1'b1;
              end
            end
          end else if (match_pos != 0 || b == boundary_bytes[0]) begin
            if (b != boundary_bytes[match_pos]) begin
              match_pos = 0;
            end else begin
              match_pos++;
              if (match_pos == len_v) begin
                match_pos = 0;
                done      = 1'b1;
              end
            end
          end
          if (done) begin
            end_v      = stream_pos - len_v;
            data_end_v = end_v;
            // Strip an LF, or a CRLF, directly in front of the boundary.
            if (lf_seen_pos + len_v == stream_pos - 32'd1) begin
              data_end_v = data_end_v - 32'd1;
              if (cr_seen_pos + 32'd1 == lf_seen_pos) data_end_v = data_end_v - 32'd1;
            end
            report.matched       = 1'b1;
            report.part_end      = end_v;
            report.part_data_end = data_end_v;
            queue_report(report);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Compare each accepted result word with the oldest expected report.
  always @(posedge clk) begin : check_results
    mbs_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_count() == 0) begin
        $display("%0t: unexpected word: expected none actual matched %0b end %h data_end %h",
                 $time, out_data.matched, out_data.part_end, out_data.part_data_end);
        error_count++;
      end else begin
        want = expect_ring[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        if (out_data.matched !== want.matched) begin
          $display("%0t: matched mismatch: expected %0b actual %0b", $time,
                   want.matched, out_data.matched);
          error_count++;
        end
        if (out_data.part_end !== want.part_end) begin
          $display("%0t: part_end mismatch: expected %h actual %h", $time,
                   want.part_end, out_data.part_end);
          error_count++;
        end
        if (out_data.part_data_end !== want.part_data_end) begin
          $display("%0t: part_data_end mismatch: expected %h actual %h", $time,
                   want.part_data_end, out_data.part_data_end);
          error_count++;
        end
      end
    end
  end

  // Present one word, hold it until accepted, then update the model.
  task automatic send_word(input mbs_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    scan_word(w);
    words_sent++;
  endtask

  // Fill the fields that the opcode does not use with noise.
  function automatic mbs_pkg::in_word_t make_word(input logic [1:0] op,
                                                  input logic [7:0] value);
    mbs_pkg::in_word_t w;
    w.opcode       = op;
    w.data_byte    = value;
    w.load_index   = 7'($urandom);
    w.start_offset = $urandom;
    return w;
  endfunction

  task automatic send_body(input logic [7:0] value);
    send_word(make_word(mbs_pkg::OP_BODY, value));
  endtask

  task automatic send_load(input logic [6:0] index, input logic [7:0] value);
    mbs_pkg::in_word_t w;
    w            = make_word(mbs_pkg::OP_LOAD, value);
    w.load_index = index;
    send_word(w);
  endtask

  task automatic send_start(input logic [31:0] offset);
    mbs_pkg::in_word_t w;
    w              = make_word(mbs_pkg::OP_START, 8'($urandom));
    w.start_offset = offset;
    send_word(w);
  endtask

  // Drop valid and let every expected report come out, plus settling time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram both registers once the scanner has gone quiet.
  task automatic set_config(input logic [7:0] length, input logic recheck);
    wait_idle();
    write_reg(ADDR_LENGTH, {24'd0, length});
    write_reg(ADDR_RECHECK, {31'd0, recheck});
    cfg_length  = length;
    cfg_recheck = recheck;
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(5))
      0: return CH_DASH;
      1: return mbs_pkg::CH_CR;
      2: return mbs_pkg::CH_LF;
      3: return CH_A;
      4: return CH_B;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short boundaries; now and then the full store or beyond it.
  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'd0;
    if (r < 75) return 8'($urandom_range(1, 6));
    if (r < 94) return 8'($urandom_range(7, 24));
    if (r < 97) return 8'(BOUNDARY_DEPTH);
    return 8'($urandom_range(BOUNDARY_DEPTH + 1, 255));
  endfunction

  // Without a boundary each body byte reports itself; offsets wrap.
  task automatic test_no_boundary();
    set_config(8'd0, 1'b0);
    send_start(32'hFFFF_FFFE);
    send_body(mbs_pkg::CH_CR);
    send_body(mbs_pkg::CH_LF);
    send_word(make_word(OP_UNUSED, 8'hFF));
    send_body(8'hFF);
    send_body(8'h00);
  endtask

  // Load the whole store: "--ab" up front, text bytes after it.
  task automatic test_store_load();
    int i;
    send_load(7'd0, CH_DASH);
    send_load(7'd1, CH_DASH);
    send_load(7'd2, CH_A);
    send_load(7'd3, CH_B);
    for (i = 4; i < BOUNDARY_DEPTH; i++) send_load(7'(i), pick_text_byte());
  endtask

  // CRLF before the boundary, then LF alone across the offset wrap.
  task automatic test_line_endings();
    set_config(8'd4, 1'b0);
    send_start(32'd100);
    send_body(mbs_pkg::CH_CR);
    send_body(mbs_pkg::CH_LF);
    send_body(CH_DASH);
    send_body(CH_DASH);
    send_body(CH_A);
    send_body(CH_B);
    send_start(32'hFFFF_FFFD);
    send_body(mbs_pkg::CH_LF);
    send_body(CH_DASH);
    send_body(CH_DASH);
    send_body(CH_A);
    send_body(CH_B);
  endtask

  // "----ab" completes only when the breaking dash may restart the match.
  task automatic test_recheck_modes();
    int  pass_no;
    logic [7:0] text [6];
    text = '{CH_DASH, CH_DASH, CH_DASH, CH_DASH, CH_A, CH_B};
    for (pass_no = 0; pass_no < 2; pass_no++) begin
      set_config(8'd4, pass_no[0]);
      foreach (text[i]) send_body(text[i]);
    end
  endtask

  // Shrink the length under a partial match, then a one-byte boundary.
  task automatic test_stale_and_short();
    set_config(8'd128, 1'b1);
    send_body(CH_DASH);
    send_body(CH_DASH);
    set_config(8'd2, 1'b1);
    send_body(CH_DASH);
    send_body(CH_DASH);
    set_config(8'd1, 1'b0);
    send_body(CH_DASH);
  endtask

  // A length past the store depth is clamped to the depth.
  task automatic test_long_length();
    set_config(8'd255, 1'b0);
    send_body(CH_DASH);
    send_body(CH_DASH);
    send_body(CH_A);
  endtask

  // About half boundaries with random line endings, some cut short or corrupted,
  // mixed with noise, store rewrites, part starts and unused opcodes.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int quota);
    int stop_at;
    int segment_end;
    int r;
    int eff;
    int cut;
    int bad_at;
    int i;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    stop_at        = words_sent + quota;
    while (words_sent < stop_at) begin
      set_config(pick_length(), 1'($urandom_range(1)));
      eff         = (cfg_length > BOUNDARY_DEPTH) ? BOUNDARY_DEPTH : int'(cfg_length);
      segment_end = words_sent + $urandom_range(20, 50);
      while (words_sent < segment_end && words_sent < stop_at) begin
        r = $urandom_range(99);
        if (r < 50 && eff > 0) begin
          repeat ($urandom_range(3)) send_body(pick_text_byte());
          case ($urandom_range(3))
            1: begin
              send_body(mbs_pkg::CH_LF);
            end
            2: begin
              send_body(mbs_pkg::CH_CR);
              send_body(mbs_pkg::CH_LF);
            end
            3: begin
              send_body(mbs_pkg::CH_CR);
            end
            default: begin
            end
          endcase
          cut    = eff;
          bad_at = -1;
          if ($urandom_range(99) < 20) begin
            cut = int'($urandom_range(eff - 1));
          end else if ($urandom_range(99) < 15) begin
            bad_at = int'($urandom_range(eff - 1));
          end
          for (i = 0; i < cut; i++) begin
            if (i == bad_at) send_body(pick_text_byte());
            else send_body(boundary_bytes[i]);
          end
        end else if (r < 62) begin
          send_body(pick_text_byte());
        end else if (r < 72) begin
          if (eff > 0 && $urandom_range(1)) begin
            send_load(7'($urandom_range(eff - 1)), pick_text_byte());
          end else begin
            send_load(7'($urandom_range(BOUNDARY_DEPTH - 1)), pick_text_byte());
          end
        end else if (r < 80) begin
          if ($urandom_range(1)) send_start($urandom);
          else send_start(32'hFFFF_FFF0 + $urandom_range(15));
        end else if (r < 84) begin
          send_word(make_word(OP_UNUSED, 8'($urandom)));
        end else begin
          repeat ($urandom_range(1, 4)) send_body(8'($urandom));
        end
      end
    end
  endtask

  initial begin
    match_pos   = 0;
    stream_pos  = '0;
    cr_seen_pos = '0;
    lf_seen_pos = '0;
    cfg_length  = '0;
    cfg_recheck = 1'b0;
    foreach (boundary_bytes[i]) boundary_bytes[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_boundary();
    test_store_load();
    test_line_endings();
    test_recheck_modes();
    test_stale_and_short();
    test_long_length();
    test_random_traffic(0, 0, 245);
    test_random_traffic(80, 0, 245);
    test_random_traffic(0, 80, 245);
    test_random_traffic(18, 18, 245);

    wait_idle();
    if (error_count == 0 && pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
